// ===== sv/afr_pkg.sv =====
// Package: shared constants, types and codes of the addressed frame receiver.
package afr_pkg;

	// Bytes that one frame buffer holds
	localparam int FRAME_BYTES = 32;
	// Frames that may wait for emission while the next one is received
	localparam int QUEUE_DEPTH = 2;

	localparam int AW     = $clog2(FRAME_BYTES);
	localparam int BUF_W  = $clog2(QUEUE_DEPTH);
	localparam int MEM_AW = BUF_W + AW;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// Length bytes at or above this value drop the frame
	localparam logic [7:0] LEN_LIMIT = 8'(FRAME_BYTES - 3);

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_START_BYTE = 2'd0,
		REG_OWN_ADDR   = 2'd1,
		REG_BCAST_ADDR = 2'd2
	} afr_reg_t;

	// Parser phases
	typedef enum logic [2:0] {
		PH_WAIT = 3'd0,
		PH_DEST = 3'd1,
		PH_SRC  = 3'd2,
		PH_LEN  = 3'd3,
		PH_DATA = 3'd4,
		PH_SUM  = 3'd5
	} afr_phase_t;

	// Write into the frame store
	typedef struct packed {
		logic              en;
		logic [MEM_AW-1:0] addr;
		logic [7:0]        data;
	} afr_wr_t;

	// Frame descriptor handoff between parser and emitter
	typedef struct packed {
		logic          push;
		logic [AW-1:0] total;
	} afr_push_t;

endpackage

// ===== sv/afr_if.sv =====
// Interfaces: receive byte channel, frame byte channel and configuration write channel.
interface afr_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface afr_frame_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       frame_last;

	modport source (output valid, output frame_byte, output frame_last, input ready);
	modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface

interface afr_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [7:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/afr_front.sv =====
// Front part: configuration registers, frame parser and frame store writes.
module afr_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rx_valid,
	output logic                       rx_ready,
	input  logic [7:0]                 rx_byte,
	input  logic                       cfg_valid,
	input  logic [1:0]                 cfg_index,
	input  logic [7:0]                 cfg_data,
	input  logic                       q_full,
	output afr_pkg::afr_wr_t           wr,
	output afr_pkg::afr_push_t         push
);

	afr_pkg::afr_phase_t          phase_q, phase_d;
	logic [afr_pkg::AW-1:0]       count_q, count_d;
	logic [7:0]                   sum_q, sum_d;
	logic [afr_pkg::BUF_W-1:0]    buf_q;
	logic [7:0]                   dest_q;
	logic [afr_pkg::AW-1:0]       len_q;
	logic [7:0]                   start_byte_q, own_addr_q, bcast_addr_q;
	logic                         accept;
	logic                         put;
	logic                         data_done;

	// Configuration registers; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= 8'd2;
			own_addr_q   <= 8'd0;
			bcast_addr_q <= 8'd255;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				afr_pkg::REG_START_BYTE: start_byte_q <= cfg_data;
				afr_pkg::REG_OWN_ADDR:   own_addr_q   <= cfg_data;
				afr_pkg::REG_BCAST_ADDR: bcast_addr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Hold a new frame at the byte after its start byte until a buffer is free
	assign rx_ready  = !(phase_q == afr_pkg::PH_DEST && q_full);
	assign accept    = rx_valid && rx_ready;
	assign data_done = ({1'b0, count_q} == ({1'b0, len_q} + (afr_pkg::AW+1)'(2)));

	// Next phase, store writes and descriptor push
	always_comb begin
		phase_d    = phase_q;
		count_d    = count_q;
		sum_d      = sum_q;
		put        = 1'b0;
		push.push  = 1'b0;
		push.total = len_q + afr_pkg::AW'(3);
		if (accept) begin
			unique case (phase_q)
				afr_pkg::PH_WAIT: begin
					if (rx_byte == start_byte_q) begin
						count_d = '0;
						sum_d   = '0;
						phase_d = afr_pkg::PH_DEST;
					end
				end
				afr_pkg::PH_DEST: begin
					put     = 1'b1;
					count_d = count_q + 1'b1;
					phase_d = afr_pkg::PH_SRC;
				end
				afr_pkg::PH_SRC: begin
					put     = 1'b1;
					count_d = count_q + 1'b1;
					phase_d = afr_pkg::PH_LEN;
				end
				afr_pkg::PH_LEN: begin
					if (rx_byte != 8'd0 && rx_byte < afr_pkg::LEN_LIMIT) begin
						put     = 1'b1;
						count_d = count_q + 1'b1;
						phase_d = afr_pkg::PH_DATA;
					end else begin
						phase_d = afr_pkg::PH_WAIT;
					end
				end
				afr_pkg::PH_DATA: begin
					put = 1'b1;
					if (data_done) begin
						phase_d = afr_pkg::PH_SUM;
					end else begin
						count_d = count_q + 1'b1;
					end
				end
				afr_pkg::PH_SUM: begin
					push.push = (sum_q == rx_byte) &&
						(dest_q == bcast_addr_q || dest_q == own_addr_q);
					phase_d   = afr_pkg::PH_WAIT;
				end
				default: begin
					phase_d = afr_pkg::PH_WAIT;
				end
			endcase
			if (put) begin
				sum_d = sum_q + rx_byte;
			end
		end
	end

	assign wr.en   = put;
	assign wr.addr = {buf_q, count_q};
	assign wr.data = rx_byte;

	// Parser state; advance the write buffer on every queued frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= afr_pkg::PH_WAIT;
			count_q <= '0;
			sum_q   <= '0;
			buf_q   <= '0;
		end else begin
			phase_q <= phase_d;
			count_q <= count_d;
			sum_q   <= sum_d;
			if (push.push) begin
				buf_q <= buf_q + 1'b1;
			end
		end
	end

	// Keep destination and length of the frame in progress
	always_ff @(posedge clk) begin
		if (accept && phase_q == afr_pkg::PH_DEST) begin
			dest_q <= rx_byte;
		end
		if (accept && phase_q == afr_pkg::PH_LEN) begin
			len_q <= rx_byte[afr_pkg::AW-1:0];
		end
	end

endmodule

// ===== sv/afr_queue.sv =====
// Descriptor queue: byte totals of accepted frames waiting for emission.
module afr_queue (
	input  logic                       clk,
	input  logic                       arst_n,
	input  afr_pkg::afr_push_t         push,
	input  logic                       pop,
	output logic                       full,
	output logic                       nonempty,
	output logic [afr_pkg::AW-1:0]     head_total
);

	logic [afr_pkg::AW-1:0]     entry_q [afr_pkg::QUEUE_DEPTH];
	logic [afr_pkg::BUF_W-1:0]  head_q, tail_q;
	logic [afr_pkg::QCNT_W-1:0] count_q;

	assign full       = (count_q == afr_pkg::QCNT_W'(afr_pkg::QUEUE_DEPTH));
	assign nonempty   = (count_q != '0);
	assign head_total = entry_q[head_q];

	// Store the pushed total
	always_ff @(posedge clk) begin
		if (push.push) begin
			entry_q[tail_q] <= push.total;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push.push) begin
				tail_q <= tail_q + 1'b1;
			end
			if (pop) begin
				head_q <= head_q + 1'b1;
			end
			if (push.push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push.push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/afr_back.sv =====
// Back part: frame store memory and byte emitter with an output register.
module afr_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  afr_pkg::afr_wr_t           wr,
	input  logic                       q_nonempty,
	input  logic [afr_pkg::AW-1:0]     q_total,
	output logic                       q_pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [7:0]                 out_byte,
	output logic                       out_last
);

	logic [7:0]                  store_q [2**afr_pkg::MEM_AW];
	logic [afr_pkg::AW-1:0]      idx_q;
	logic [afr_pkg::BUF_W-1:0]   rd_buf_q;
	logic [7:0]                  rdata_s1;
	logic                        rd_valid_s1;
	logic                        rd_last_s1;
	logic                        out_valid_q;
	logic [7:0]                  out_byte_q;
	logic                        out_last_q;
	logic                        load_out;
	logic                        issue;
	logic                        last_issue;

	assign load_out   = rd_valid_s1 && (!out_valid_q || out_ready);
	assign issue      = q_nonempty && (!rd_valid_s1 || load_out);
	assign last_issue = (idx_q == q_total - 1'b1);
	assign q_pop      = issue && last_issue;

	// Frame store: written by the parser, read here one byte per issue
	always_ff @(posedge clk) begin
		if (wr.en) begin
			store_q[wr.addr] <= wr.data;
		end
		if (issue) begin
			rdata_s1   <= store_q[{rd_buf_q, idx_q}];
			rd_last_s1 <= last_issue;
		end
		if (load_out) begin
			out_byte_q <= rdata_s1;
			out_last_q <= rd_last_s1;
		end
	end

	// Advance the read position; move to the next buffer after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			rd_buf_q    <= '0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				if (last_issue) begin
					idx_q    <= '0;
					rd_buf_q <= rd_buf_q + 1'b1;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
				rd_valid_s1 <= 1'b1;
			end else if (load_out) begin
				rd_valid_s1 <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

endmodule

// ===== sv/addressed_frame_receiver_core.sv =====
// Top level: addressed frame receiver with decoupled parser and frame emitter.
//
// Channel | Dir | Payload             | Item
// rx      | in  | rx_byte[7:0]        | one received serial byte
// frame   | out | frame_byte, last    | one byte of an accepted frame
// cfg     | in  | index[1:0], data    | one register write (always ready)
//
// The parser takes one byte per cycle; an accepted frame of N bytes
// (N = length + 3, at most 31) leaves at one byte per cycle while the
// frame channel is ready. Two frame buffers let a frame be received while
// the previous one is emitted; the first byte after a start byte stalls
// only while both buffers still wait for emission.
// arst_n clears parser, queue and emitter; the frame store needs no clearing.
module addressed_frame_receiver_core (
	input  logic            clk,
	input  logic            arst_n,
	afr_rx_if.sink          rx,
	afr_frame_if.source     frame,
	afr_cfg_if.sink         cfg
);

	afr_pkg::afr_wr_t          wr;
	afr_pkg::afr_push_t        push;
	logic                      q_full;
	logic                      q_nonempty;
	logic                      q_pop;
	logic [afr_pkg::AW-1:0]    q_total;

	assign cfg.ready = 1'b1;

	afr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_valid  (rx.valid),
		.rx_ready  (rx.ready),
		.rx_byte   (rx.rx_byte),
		.cfg_valid (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.q_full    (q_full),
		.wr        (wr),
		.push      (push)
	);

	afr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pop        (q_pop),
		.full       (q_full),
		.nonempty   (q_nonempty),
		.head_total (q_total)
	);

	afr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (wr),
		.q_nonempty (q_nonempty),
		.q_total    (q_total),
		.q_pop      (q_pop),
		.out_valid  (frame.valid),
		.out_ready  (frame.ready),
		.out_byte   (frame.frame_byte),
		.out_last   (frame.frame_last)
	);

endmodule

// ===== tb/addressed_frame_receiver_core_tb.sv =====
// Testbench: addressed frame receiver fed with byte streams and checked by a frame predictor.
`timescale 1ns / 1ps

module addressed_frame_receiver_core_tb;

	// Index with no register behind it; writes to it are ignored
	localparam logic [1:0] REG_NONE = 2'd3;

	typedef struct {
		logic [7:0] fbyte;
		logic       flast;
	} frame_beat_t;

	// Predicts accepted frames from received bytes and checks emitted bytes
	class frame_scoreboard;
		logic [7:0]           start_val;
		logic [7:0]           own_val;
		logic [7:0]           bcast_val;
		afr_pkg::afr_phase_t  phase;
		int                   fill_idx;
		logic [7:0]           csum;
		logic [7:0]           store [afr_pkg::FRAME_BYTES];
		frame_beat_t          expected_beats [$];
		int                   fail_count;
		int                   reported;

		function new();
			start_val  = 8'd2;
			own_val    = 8'd0;
			bcast_val  = 8'hFF;
			phase      = afr_pkg::PH_WAIT;
			fill_idx   = 0;
			csum       = 8'd0;
			fail_count = 0;
			reported   = 0;
			foreach (store[i]) store[i] = 8'd0;
		endfunction

		function void note_fail(string msg);
			fail_count++;
			if (reported < 10) begin
				reported++;
				$display("ERROR at %0t: %s", $time, msg);
			end
		endfunction

		function void write_reg(logic [1:0] idx, logic [7:0] val);
			case (idx)
				afr_pkg::REG_START_BYTE: start_val = val;
				afr_pkg::REG_OWN_ADDR:   own_val = val;
				afr_pkg::REG_BCAST_ADDR: bcast_val = val;
				default: ;
			endcase
		endfunction

		// Store one frame byte and fold it into the running checksum
		function void put(logic [7:0] b);
			if (fill_idx < afr_pkg::FRAME_BYTES) store[fill_idx] = b;
			csum = csum + b;
		endfunction

		// Advance the parser by one received item
		function void take_rx_byte(logic [7:0] b);
			int total;
			frame_beat_t beat;
			case (phase)
				afr_pkg::PH_WAIT: begin
					if (b == start_val) begin
						fill_idx = 0;
						csum = 8'd0;
						phase = afr_pkg::PH_DEST;
					end
				end
				afr_pkg::PH_DEST: begin
					put(b);
					fill_idx++;
					phase = afr_pkg::PH_SRC;
				end
				afr_pkg::PH_SRC: begin
					put(b);
					fill_idx++;
					phase = afr_pkg::PH_LEN;
				end
				afr_pkg::PH_LEN: begin
					if (b != 8'd0 && b < afr_pkg::LEN_LIMIT) begin
						put(b);
						fill_idx++;
						phase = afr_pkg::PH_DATA;
					end else begin
						phase = afr_pkg::PH_WAIT;
					end
				end
				afr_pkg::PH_DATA: begin
					put(b);
					if (fill_idx >= int'(store[2]) + 2) phase = afr_pkg::PH_SUM;
					else fill_idx++;
				end
				afr_pkg::PH_SUM: begin
					// Emit the stored frame on a good checksum to our address
					if (csum == b && (store[0] == bcast_val || store[0] == own_val)) begin
						total = int'(store[2]) + 3;
						if (total > afr_pkg::FRAME_BYTES) total = afr_pkg::FRAME_BYTES;
						for (int k = 0; k < total; k++) begin
							beat.fbyte = store[k];
							beat.flast = (k == total - 1);
							expected_beats.push_back(beat);
						end
					end
					phase = afr_pkg::PH_WAIT;
				end
				default: phase = afr_pkg::PH_WAIT;
			endcase
		endfunction

		// Compare one emitted item with the oldest expected one
		function void check_frame_byte(logic [7:0] b, logic l);
			frame_beat_t want;
			if (expected_beats.size() == 0) begin
				note_fail($sformatf("unexpected frame byte %02h last %0b", b, l));
				return;
			end
			want = expected_beats.pop_front();
			if (b !== want.fbyte || l !== want.flast)
				note_fail($sformatf("frame byte %02h last %0b, expected %02h last %0b",
					b, l, want.fbyte, want.flast));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   no_idle;
	int   rx_sent;
	frame_scoreboard sb;

	afr_rx_if    rx_ch();
	afr_frame_if frame_ch();
	afr_cfg_if   cfg_ch();

	addressed_frame_receiver_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.frame  (frame_ch),
		.cfg    (cfg_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs
	initial begin
		#3_000_000;
		$display("Verification failed");
		$finish;
	end

	// Stall the frame channel at random
	always @(negedge clk) begin
		frame_ch.ready <= arst_n && (no_idle || $urandom_range(99) >= 16);
	end

	// Check every accepted frame item
	always @(posedge clk) begin
		if (arst_n && frame_ch.valid === 1'b1 && frame_ch.ready === 1'b1)
			sb.check_frame_byte(frame_ch.frame_byte, frame_ch.frame_last);
	end

	// Send one received byte; valid stays high for a following item
	task automatic send_rx(input logic [7:0] b);
		while (!no_idle && $urandom_range(99) < 16) begin
			rx_ch.valid <= 1'b0;
			@(negedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		@(posedge clk);
		while (rx_ch.ready !== 1'b1) @(posedge clk);
		sb.take_rx_byte(b);
		rx_sent++;
		@(negedge clk);
	endtask

	// Write one register; caller drops valid after the last write
	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		@(posedge clk);
		while (cfg_ch.ready !== 1'b1) @(posedge clk);
		sb.write_reg(idx, val);
		@(negedge clk);
	endtask

	// Full frame with a checksum, optionally corrupted by flip
	task automatic send_frame(input logic [7:0] dest, input logic [7:0] src,
			input logic [7:0] len, input bit fixed, input logic [7:0] fill,
			input logic [7:0] flip);
		logic [7:0] sum;
		logic [7:0] d;
		sum = dest + src + len;
		send_rx(sb.start_val);
		send_rx(dest);
		send_rx(src);
		send_rx(len);
		for (int k = 0; k < int'(len); k++) begin
			d = fixed ? fill : 8'($urandom);
			sum = sum + d;
			send_rx(d);
		end
		send_rx(sum ^ flip);
	endtask

	// Frame header whose length byte drops it
	task automatic send_len_drop(input logic [7:0] dest, input logic [7:0] src,
			input logic [7:0] len);
		send_rx(sb.start_val);
		send_rx(dest);
		send_rx(src);
		send_rx(len);
	endtask

	// Feed bytes until the parser waits for a start byte again
	task automatic close_frame();
		while (sb.phase != afr_pkg::PH_WAIT)
			send_rx(sb.phase == afr_pkg::PH_LEN ? 8'h00 : 8'($urandom));
	endtask

	// Mostly well-formed frames, with drops, noise and cut frames mixed in
	task automatic run_random(input int count);
		int target;
		int r;
		int n;
		logic [7:0] dest;
		logic [7:0] len;
		logic [7:0] flip;
		target = rx_sent + count;
		while (rx_sent < target) begin
			r = $urandom_range(99);
			if (r < 70) begin
				n = $urandom_range(9);
				dest = (n < 4) ? sb.own_val : (n < 7) ? sb.bcast_val : 8'($urandom);
				len = ($urandom_range(9) == 0) ? 8'($urandom_range(28, 1))
					: 8'($urandom_range(8, 1));
				if ($urandom_range(19) == 0) len = afr_pkg::LEN_LIMIT - 8'd1;
				flip = ($urandom_range(9) == 0) ? 8'($urandom_range(255, 1)) : 8'd0;
				send_frame(dest, 8'($urandom), len, 1'b0, 8'd0, flip);
			end else if (r < 80) begin
				len = ($urandom_range(1) == 0) ? 8'd0
					: 8'($urandom_range(255, afr_pkg::LEN_LIMIT));
				send_len_drop(($urandom_range(1) == 0) ? sb.own_val : 8'($urandom),
					8'($urandom), len);
			end else if (r < 90) begin
				n = $urandom_range(3, 1);
				repeat (n) send_rx(8'($urandom));
			end else begin
				send_rx(sb.start_val);
				n = $urandom_range(4, 1);
				repeat (n) send_rx(8'($urandom));
			end
		end
	endtask

	// Bring the block to rest before touching registers
	task automatic drain_idle();
		close_frame();
		rx_ch.valid <= 1'b0;
		while (sb.expected_beats.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic reconfigure(input logic [7:0] start_v, input logic [7:0] own_v,
			input logic [7:0] bcast_v);
		drain_idle();
		write_reg(afr_pkg::REG_START_BYTE, start_v);
		write_reg(afr_pkg::REG_OWN_ADDR, own_v);
		write_reg(afr_pkg::REG_BCAST_ADDR, bcast_v);
		write_reg(REG_NONE, 8'($urandom));
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		int waited;
		sb = new();
		no_idle = 1'b0;
		rx_sent = 0;
		arst_n = 1'b0;
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = 8'd0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = afr_pkg::REG_START_BYTE;
		cfg_ch.data = 8'd0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: length drops, start byte inside a frame, bad sum, broadcast
		send_len_drop(8'h00, 8'h11, 8'h00);
		send_len_drop(8'h00, 8'h11, afr_pkg::LEN_LIMIT);
		send_frame(8'h00, 8'h02, 8'h01, 1'b1, 8'h02, 8'h00);
		send_frame(8'hFF, 8'h80, 8'h02, 1'b1, 8'h00, 8'h01);
		send_frame(8'hFF, 8'h7F, 8'h01, 1'b1, 8'hFF, 8'h00);

		run_random(80);

		// Extreme register values with no stalls on either side
		reconfigure(8'h00, 8'hFF, 8'h00);
		no_idle = 1'b1;
		run_random(80);
		no_idle = 1'b0;

		reconfigure(8'hFF, 8'hA5, 8'h5A);
		run_random(80);

		reconfigure(8'($urandom), 8'($urandom), 8'($urandom));
		run_random(80);

		// Wait out the last frames, then report
		close_frame();
		rx_ch.valid <= 1'b0;
		waited = 0;
		while (sb.expected_beats.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (40) @(posedge clk);
		if (sb.expected_beats.size() != 0)
			sb.note_fail($sformatf("%0d frame bytes never emitted",
				sb.expected_beats.size()));
		if (sb.fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
